@@ hw/rtl/fcrc_pkg.sv @@
package fcrc_pkg;

	localparam logic [7:0] HDR_BYTE      = 8'hAF;
	localparam logic [7:0] CRC_POLY      = 8'h1D;
	localparam logic [7:0] CRC_INIT      = 8'hFF;
	localparam logic [7:0] MAX_LEN_RESET = 8'd64;

	// number of result groups the output queue holds
	localparam int unsigned GQ_DEPTH = 2;
	localparam int unsigned GQ_PTR_W = $clog2(GQ_DEPTH);
	localparam int unsigned GQ_CNT_W = $clog2(GQ_DEPTH + 1);

	typedef enum logic [2:0] {
		PH_HUNT,
		PH_TYPE,
		PH_LENLO,
		PH_LENHI,
		PH_PAYLOAD,
		PH_CRC
	} phase_t;

	typedef enum logic [1:0] {
		KIND_PASS,
		KIND_PAYLOAD,
		KIND_GOOD,
		KIND_BAD
	} kind_t;

	typedef struct packed {
		phase_t     phase;
		logic [7:0] held_type;
		logic [7:0] held_len_low;
		logic [7:0] accepted_len;
		logic [7:0] bytes_left;
		logic [7:0] crc;
	} rx_state_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] data;
		logic [7:0] ftype;
		logic [7:0] flen;
	} result_t;

	// all results caused by one input byte, res[0] first
	typedef struct packed {
		logic [1:0]        count;
		result_t [2:0]     res;
	} group_t;

	function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] v;
		v = crc ^ b;
		for (int k = 0; k < 8; k++) begin
			v = v[7] ? ({v[6:0], 1'b0} ^ CRC_POLY) : {v[6:0], 1'b0};
		end
		return v;
	endfunction

endpackage

@@ hw/rtl/fcrc_decode.sv @@
// One received byte against the current receiver state: next state plus
// the results it causes. A rejected header replays its three held bytes.
module fcrc_decode (
	input  fcrc_pkg::rx_state_t st,
	input  logic [7:0]          rx,
	input  logic [7:0]          max_len,
	output fcrc_pkg::rx_state_t st_next,
	output fcrc_pkg::group_t    grp
);

	always_comb begin
		fcrc_pkg::phase_t ph;
		logic [7:0]       crc;
		logic [7:0]       ht;
		logic [7:0]       hl;
		logic [1:0]       n;
		logic [7:0]       rb [3];

		st_next = st;
		grp     = '0;
		ph      = fcrc_pkg::PH_HUNT;
		crc     = fcrc_pkg::CRC_INIT;
		ht      = st.held_type;
		hl      = st.held_len_low;
		n       = 2'd0;
		rb[0]   = st.held_type;
		rb[1]   = st.held_len_low;
		rb[2]   = rx;

		case (st.phase)
			fcrc_pkg::PH_TYPE: begin
				st_next.held_type = rx;
				st_next.crc       = fcrc_pkg::crc8_update(st.crc, rx);
				st_next.phase     = fcrc_pkg::PH_LENLO;
			end
			fcrc_pkg::PH_LENLO: begin
				st_next.held_len_low = rx;
				st_next.crc          = fcrc_pkg::crc8_update(st.crc, rx);
				st_next.phase        = fcrc_pkg::PH_LENHI;
			end
			fcrc_pkg::PH_LENHI: begin
				if (rx != 8'd0 || st.held_len_low > max_len) begin
					// header dropped; type, len low, len high seen again from hunt.
					// Three bytes cannot get back to a length check.
					for (int i = 0; i < 3; i++) begin
						case (ph)
							fcrc_pkg::PH_TYPE: begin
								ht  = rb[i];
								crc = fcrc_pkg::crc8_update(crc, rb[i]);
								ph  = fcrc_pkg::PH_LENLO;
							end
							fcrc_pkg::PH_LENLO: begin
								hl  = rb[i];
								crc = fcrc_pkg::crc8_update(crc, rb[i]);
								ph  = fcrc_pkg::PH_LENHI;
							end
							default: begin
								if (rb[i] == fcrc_pkg::HDR_BYTE) begin
									crc = fcrc_pkg::CRC_INIT;
									ph  = fcrc_pkg::PH_TYPE;
								end else begin
									grp.res[n] = '{fcrc_pkg::KIND_PASS, rb[i], 8'd0, 8'd0};
									n          = n + 2'd1;
								end
							end
						endcase
					end
					st_next.phase        = ph;
					st_next.crc          = crc;
					st_next.held_type    = ht;
					st_next.held_len_low = hl;
					grp.count            = n;
				end else begin
					st_next.crc          = fcrc_pkg::crc8_update(st.crc, rx);
					st_next.accepted_len = st.held_len_low;
					st_next.bytes_left   = st.held_len_low;
					st_next.phase        = (st.held_len_low == 8'd0) ? fcrc_pkg::PH_CRC
					                                                 : fcrc_pkg::PH_PAYLOAD;
				end
			end
			fcrc_pkg::PH_PAYLOAD: begin
				st_next.crc        = fcrc_pkg::crc8_update(st.crc, rx);
				st_next.bytes_left = st.bytes_left - 8'd1;
				if (st.bytes_left == 8'd1) begin
					st_next.phase = fcrc_pkg::PH_CRC;
				end
				grp.res[0] = '{fcrc_pkg::KIND_PAYLOAD, rx, st.held_type, st.accepted_len};
				grp.count  = 2'd1;
			end
			fcrc_pkg::PH_CRC: begin
				grp.res[0] = '{(rx == st.crc) ? fcrc_pkg::KIND_GOOD : fcrc_pkg::KIND_BAD,
				               8'd0, st.held_type, st.accepted_len};
				grp.count     = 2'd1;
				st_next.phase = fcrc_pkg::PH_HUNT;
				st_next.crc   = fcrc_pkg::CRC_INIT;
			end
			default: begin
				st_next.phase = fcrc_pkg::PH_HUNT;
				if (rx == fcrc_pkg::HDR_BYTE) begin
					st_next.crc   = fcrc_pkg::CRC_INIT;
					st_next.phase = fcrc_pkg::PH_TYPE;
				end else begin
					grp.res[0] = '{fcrc_pkg::KIND_PASS, rx, 8'd0, 8'd0};
					grp.count  = 2'd1;
				end
			end
		endcase
	end

endmodule

@@ hw/rtl/framed_crc8_receiver.sv @@
// channel  direction  handshake            payload
// in       input      in_valid/in_stall    rx_byte
// out      output     out_valid/out_stall  kind, data_byte, frame_type, frame_len, last
// cfg      input      cfg_valid/cfg_ready  max_payload_len
//
// One byte per cycle sustained while in_stall is low. A byte is decoded in the
// cycle after its accept, when the two-group result queue has room; a rejected
// header yields up to three results, sent one per cycle while out_stall is low.
// arst_n clears state to hunting, CRC 0xFF, max length 64. cfg_ready is always high.
// in_stall rises only while a decoded byte waits for a free queue slot.
module framed_crc8_receiver (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [1:0] kind,
	output logic [7:0] data_byte,
	output logic [7:0] frame_type,
	output logic [7:0] frame_len,
	output logic       last,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [7:0] max_payload_len
);

	logic                                 valid_s1;
	logic [7:0]                           byte_s1;
	fcrc_pkg::rx_state_t                  st_q;
	fcrc_pkg::rx_state_t                  st_next;
	fcrc_pkg::group_t                     grp;
	logic [7:0]                           max_len_q;
	fcrc_pkg::group_t                     gq_q [fcrc_pkg::GQ_DEPTH];
	logic [fcrc_pkg::GQ_PTR_W-1:0]        wr_ptr_q;
	logic [fcrc_pkg::GQ_PTR_W-1:0]        rd_ptr_q;
	logic [fcrc_pkg::GQ_CNT_W-1:0]        count_q;
	logic [1:0]                           sub_q;
	logic                                 q_full;
	logic                                 advance;
	logic                                 push;
	logic                                 pop;
	logic                                 out_take;
	fcrc_pkg::group_t                     cur;
	fcrc_pkg::result_t                    res;

	fcrc_decode u_decode (
		.st      (st_q),
		.rx      (byte_s1),
		.max_len (max_len_q),
		.st_next (st_next),
		.grp     (grp)
	);

	assign q_full   = (count_q == fcrc_pkg::GQ_CNT_W'(fcrc_pkg::GQ_DEPTH));
	assign advance  = valid_s1 && !q_full;
	assign push     = advance && (grp.count != 2'd0);
	assign in_stall = valid_s1 && q_full;
	assign cfg_ready = 1'b1;

	assign cur       = gq_q[rd_ptr_q];
	assign res       = cur.res[sub_q];
	assign out_valid = (count_q != '0);
	assign kind       = res.kind;
	assign data_byte  = res.data;
	assign frame_type = res.ftype;
	assign frame_len  = res.flen;
	assign last       = (sub_q == cur.count - 2'd1);
	assign out_take   = out_valid && !out_stall;
	assign pop        = out_take && last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			st_q      <= '{fcrc_pkg::PH_HUNT, 8'd0, 8'd0, 8'd0, 8'd0, fcrc_pkg::CRC_INIT};
			max_len_q <= fcrc_pkg::MAX_LEN_RESET;
			wr_ptr_q  <= '0;
			rd_ptr_q  <= '0;
			count_q   <= '0;
			sub_q     <= 2'd0;
		end else begin
			if (in_valid && !in_stall) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				st_q <= st_next;
			end
			if (cfg_valid && cfg_ready) begin
				max_len_q <= max_payload_len;
			end
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (out_take) begin
				if (last) begin
					rd_ptr_q <= rd_ptr_q + 1'b1;
					sub_q    <= 2'd0;
				end else begin
					sub_q <= sub_q + 2'd1;
				end
			end
			count_q <= count_q + fcrc_pkg::GQ_CNT_W'(push) - fcrc_pkg::GQ_CNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= rx_byte;
		end
		if (push) begin
			gq_q[wr_ptr_q] <= grp;
		end
	end

endmodule
